@@ design/fat_cluster_chain_walker_top_assert.svh @@
// assertion macros shared by the walker rtl
`ifndef FAT_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define FCCW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define FCCW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fccw_pkg.sv @@
package fccw_pkg;

  localparam int unsigned MAP_DEPTH_DEF = 4096;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned CB_W      = 21;
  localparam int unsigned BASE_W    = 48;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd2;

  localparam logic [CB_W-1:0] CB_RESET = 21'd16384;

  // chain markers, narrow and wide
  localparam logic [VAL_W-1:0] EOC_16  = 32'h0000_ffff;
  localparam logic [VAL_W-1:0] ROOT_16 = 32'h0000_fff8;
  localparam logic [VAL_W-1:0] MAX_16  = 32'h0000_fff4;
  localparam logic [VAL_W-1:0] EOC_32  = 32'hffff_ffff;
  localparam logic [VAL_W-1:0] ROOT_32 = 32'hffff_fff8;
  localparam logic [VAL_W-1:0] MAX_32  = 32'hffff_fff4;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_NEXT  = 2'd2
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_UNALLOC     = 3'd2,
    ST_INVALID     = 3'd3,
    ST_BAD_CLUSTER = 3'd4,
    ST_NO_WALK     = 3'd5
  } status_e;

  typedef struct packed {
    logic [CB_W-1:0] take;
    logic            last;
    status_e         status;
    logic            addr_en;
  } seg_t;

endpackage

@@ design/fccw_ram.sv @@
module fccw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fat_cluster_chain_walker_top.sv @@
// path: input register, classify and walk step, cluster offset multiply, base add
// throughput: one beat per cycle unless stalled, starts and advances back to back
// included; the map read for the next advance is issued with the cluster chosen
// in that cycle
// reset: walk state, configuration and pipeline valids clear asynchronously;
// the chain map is not cleared and holds garbage until written
`include "fat_cluster_chain_walker_top_assert.svh"

module fat_cluster_chain_walker_top #(
  parameter int unsigned MAP_DEPTH = fccw_pkg::MAP_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fccw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fccw_pkg::BASE_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fccw_pkg::CMD_W-1:0]     command_i,
  input  logic [fccw_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [fccw_pkg::VAL_W-1:0]     entry_value_i,
  input  logic [fccw_pkg::VAL_W-1:0]     start_cluster_i,
  input  logic [fccw_pkg::SIZE_W-1:0]    file_size_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fccw_pkg::ADDR_W-1:0]    segment_address_o,
  output logic [fccw_pkg::CB_W-1:0]      segment_bytes_o,
  output logic                           last_segment_o,
  output logic [fccw_pkg::ST_W-1:0]      status_o
);
  import fccw_pkg::*;

  localparam int unsigned AW = $clog2(MAP_DEPTH);
  localparam int unsigned PW = AW + CB_W;
  localparam logic [VAL_W-1:0] DEPTH_V = VAL_W'(MAP_DEPTH);

  // configuration
  logic              wide_q;
  logic [CB_W-1:0]   cb_q;
  logic [BASE_W-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
      cb_q   <= CB_RESET;
      base_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDE:    wide_q <= cfg_data_i[0];
        CFG_CLUSTER: cb_q   <= cfg_data_i[CB_W-1:0];
        CFG_BASE:    base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic do2;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign do2 = v1_q && rdy2;

  // stage 1: input register
  cmd_e              cmd1_q;
  logic [IDX_W-1:0]  idx1_q;
  logic [VAL_W-1:0]  val1_q;
  logic [VAL_W-1:0]  start1_q;
  logic [SIZE_W-1:0] size1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      cmd1_q   <= cmd_e'(command_i);
      idx1_q   <= entry_index_i;
      val1_q   <= entry_value_i;
      start1_q <= start_cluster_i;
      size1_q  <= file_size_i;
    end
  end

  // walk state and chain map
  logic [AW-1:0]     cur_q, cur_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic              walk_q, walk_d;
  logic              byp_q, byp_d;
  logic [VAL_W-1:0]  byp_data_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_rdata;
  logic [VAL_W-1:0]  idx_ext;

  assign idx_ext   = VAL_W'(idx1_q);
  assign ram_waddr = idx_ext[AW-1:0];

  // read address is the cluster the walk holds after this cycle
  fccw_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAP_DEPTH),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val1_q),
    .raddr_i (cur_d),
    .rdata_o (ram_rdata)
  );

  // stage 2: classify and step the walk
  logic [VAL_W-1:0]  map_val, nxt;
  logic [VAL_W-1:0]  eoc, root_end, max_id;
  logic [VAL_W-1:0]  id_sel;
  logic [SIZE_W-1:0] rem_sel;
  logic [SIZE_W-1:0] cb_ext, take32;
  logic              enter;
  seg_t              seg_d;
  logic [AW-1:0]     off_d;

  assign map_val  = byp_q ? byp_data_q : ram_rdata;
  assign nxt      = wide_q ? map_val : {16'h0000, map_val[15:0]};
  assign eoc      = wide_q ? EOC_32 : EOC_16;
  assign root_end = wide_q ? ROOT_32 : ROOT_16;
  assign max_id   = wide_q ? MAX_32 : MAX_16;
  assign cb_ext   = SIZE_W'(cb_q);
  assign take32   = (rem_sel <= cb_ext) ? rem_sel : cb_ext;

  always_comb begin
    cur_d   = cur_q;
    rem_d   = rem_q;
    walk_d  = walk_q;
    ram_we  = 1'b0;
    rem_sel = rem_q;
    id_sel  = '0;
    enter   = 1'b0;
    off_d   = '0;
    seg_d   = '{take: '0, last: 1'b0, status: ST_OK, addr_en: 1'b0};
    if (do2) begin
      unique case (cmd1_q)
        CMD_WRITE: ram_we = (idx_ext < DEPTH_V);
        CMD_START: begin
          rem_sel = size1_q;
          id_sel  = start1_q;
          enter   = 1'b1;
        end
        CMD_NEXT: begin
          if (!walk_q) begin
            seg_d.status = ST_NO_WALK;
          end else begin
            priority if (nxt == eoc || nxt == root_end) begin
              walk_d       = 1'b0;
              seg_d.last   = 1'b1;
              seg_d.status = (rem_q != '0) ? ST_SHORT : ST_OK;
            end else if (nxt == '0) begin
              walk_d       = 1'b0;
              seg_d.last   = 1'b1;
              seg_d.status = ST_UNALLOC;
            end else if (nxt > max_id) begin
              walk_d       = 1'b0;
              seg_d.last   = 1'b1;
              seg_d.status = ST_INVALID;
            end else begin
              id_sel = nxt;
              enter  = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (enter) begin
        rem_d = rem_sel;
        if (id_sel == '0 || id_sel >= DEPTH_V) begin
          walk_d       = 1'b0;
          seg_d.last   = 1'b1;
          seg_d.status = ST_BAD_CLUSTER;
        end else begin
          cur_d         = id_sel[AW-1:0];
          walk_d        = 1'b1;
          rem_d         = rem_sel - take32;
          seg_d.take    = take32[CB_W-1:0];
          seg_d.addr_en = 1'b1;
          off_d         = id_sel[AW-1:0] - AW'(1);
        end
      end
    end
  end

  // a write landing on the address being read this cycle
  assign byp_d = ram_we && (ram_waddr == cur_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      rem_q  <= '0;
      walk_q <= 1'b0;
      byp_q  <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      rem_q  <= rem_d;
      walk_q <= walk_d;
      byp_q  <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= val1_q;
  end

  seg_t          seg2_q;
  logic [AW-1:0] off2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do2) begin
      seg2_q <= seg_d;
      off2_q <= off_d;
    end
  end

  // stage 3: cluster offset times cluster size
  seg_t          seg3_q;
  logic [PW-1:0] prod3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      seg3_q  <= seg2_q;
      prod3_q <= PW'(off2_q) * PW'(cb_q);
    end
  end

  // stage 4: add base, result register
  seg_t              seg4_q;
  logic [ADDR_W-1:0] addr4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && rdy4) begin
      seg4_q  <= seg3_q;
      addr4_q <= seg3_q.addr_en ? (ADDR_W'(base_q) + ADDR_W'(prod3_q)) : '0;
    end
  end

  assign out_valid_o       = v4_q;
  assign segment_address_o = addr4_q;
  assign segment_bytes_o   = seg4_q.take;
  assign last_segment_o    = seg4_q.last;
  assign status_o          = seg4_q.status;

  `FCCW_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, in_stall_o,
    v1_q && v2_q && v3_q && v4_q, "input stalled while a stage is free")
  `FCCW_ASSERT_IMP(a_walk_cluster_nonzero, clk_i, rst_ni, walk_q,
    cur_q != '0, "active walk on cluster zero")
  `FCCW_ASSERT_IMP(a_error_ends_walk, clk_i, rst_ni,
    out_valid_o && (status_o == ST_UNALLOC || status_o == ST_INVALID ||
    status_o == ST_BAD_CLUSTER), last_segment_o, "error result without last segment")
  `FCCW_ASSERT_IMP(a_bytes_only_ok, clk_i, rst_ni, out_valid_o && segment_bytes_o != '0,
    status_o == ST_OK && !last_segment_o && segment_bytes_o <= cb_q,
    "segment bytes on a non-data result")
  `FCCW_ASSERT_NXT(a_idle_advance, clk_i, rst_ni, do2 && cmd1_q == CMD_NEXT && !walk_q,
    !walk_q, "advance without walk started a walk")

endmodule
